// ----- rtl/fcspq_pkg.sv -----
// ----------------------------------------------------------------------------
// fcspq_pkg
// Shared types, codes and the class function for the four class stable
// priority queue.
// ----------------------------------------------------------------------------
package fcspq_pkg;

    // field widths fixed by the interface
    localparam int TAG_PORT_W = 16;
    localparam int AGE_W      = 7;

    // age threshold after reset
    localparam logic [AGE_W-1:0] THRESH_RESET = 7'd60;

    // action codes
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_ENQUEUED = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_SERVED   = 2'd3;

    // class codes, higher code is served first
    localparam logic [1:0] CLASS_PLAIN   = 2'd0;
    localparam logic [1:0] CLASS_ELDER   = 2'd1;
    localparam logic [1:0] CLASS_SICK    = 2'd2;
    localparam logic [1:0] CLASS_ELDSICK = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } t_state;

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift;   // dequeue: take the right neighbor
        logic load;    // this cell is the tail slot for a new entry
        logic active;  // sweep token sits here: compare with left neighbor
    } t_cell_ctrl;

    // class of one entry against the current threshold
    function automatic logic [1:0] class_of(input logic [AGE_W-1:0] age,
                                            input logic             flag,
                                            input logic [AGE_W-1:0] thresh);
        logic elderly;
        elderly = (age >= thresh);
        if (flag && elderly) begin
            return CLASS_ELDSICK;
        end else if (flag) begin
            return CLASS_SICK;
        end else if (elderly) begin
            return CLASS_ELDER;
        end
        return CLASS_PLAIN;
    endfunction

endpackage

// ----- rtl/four_class_stable_priority_queue_top.sv -----
// ----------------------------------------------------------------------------
// four_class_stable_priority_queue_top
// Bounded four class priority queue built as a chain of entry cells that
// keeps arrival order inside each class.
// ----------------------------------------------------------------------------
// A dequeue, a dequeue on an empty queue, an enqueue on a full queue and an
// enqueue into an empty queue each load their result without a sweep. An
// enqueue into a non-empty queue lands in the tail cell; a compare-and-swap
// token then walks one cell per cycle from the tail to the head, the enqueued
// result is issued when it arrives and the input is stalled while it walks.
// One result register sits on the output: the next item is taken in the same
// cycle that a waiting result leaves, and the input stalls while a result is
// held off downstream. Classes always use the current threshold.
module four_class_stable_priority_queue_top
    import fcspq_pkg::*;
#(
    parameter int CAPACITY = 128,
    parameter int TAG_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [AGE_W-1:0]      i_cfg_wdata,
    // input item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic [TAG_PORT_W-1:0] i_tag,
    input  logic [AGE_W-1:0]      i_age,
    input  logic                  i_health_flag,
    // result item channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic [TAG_PORT_W-1:0] o_out_tag,
    output logic [AGE_W-1:0]      o_out_age,
    output logic                  o_out_health_flag
);

    localparam int SW = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
    localparam int EW = SW + AGE_W + 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = $clog2(CAPACITY);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [PW-1:0]   r_pos, n_pos;
    logic [AGE_W-1:0] r_thresh;

    logic            r_out_valid;
    logic [1:0]      r_out_status;
    logic [SW-1:0]   r_out_tag;
    logic [AGE_W-1:0] r_out_age;
    logic            r_out_flag;

    logic            out_free, acc, is_enq, full;
    logic            enq_go, deq_go, sweep_go, out_load, out_head;
    logic [1:0]      out_status;
    logic [EW-1:0]   new_entry;

    logic [EW-1:0]   w_entry [CAPACITY];
    logic [1:0]      w_class [CAPACITY];
    logic            w_swap  [CAPACITY];

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !out_free;
    assign acc        = i_in_valid && !o_in_stall;
    assign is_enq     = (i_action == ACT_ENQ);
    assign full       = (r_count == CW'(CAPACITY));
    assign new_entry  = {i_tag[SW-1:0], i_age, i_health_flag};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc && is_enq && !full && (r_count != '0)) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (r_pos == PW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        enq_go     = 1'b0;
        deq_go     = 1'b0;
        sweep_go   = 1'b0;
        out_load   = 1'b0;
        out_head   = 1'b0;
        out_status = STAT_ENQUEUED;
        n_count    = r_count;
        n_pos      = r_pos;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (is_enq) begin
                        if (full) begin
                            out_load   = 1'b1;
                            out_status = STAT_FULL;
                        end else begin
                            enq_go  = 1'b1;
                            n_count = r_count + CW'(1);
                            n_pos   = r_count[PW-1:0];
                            // first entry needs no sweep
                            if (r_count == '0) begin
                                out_load   = 1'b1;
                                out_status = STAT_ENQUEUED;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            out_load   = 1'b1;
                            out_status = STAT_EMPTY;
                        end else begin
                            out_load   = 1'b1;
                            out_head   = 1'b1;
                            out_status = STAT_SERVED;
                            deq_go     = 1'b1;
                            n_count    = r_count - CW'(1);
                        end
                    end
                end
            end
            ST_SWEEP: begin
                sweep_go = 1'b1;
                n_pos    = r_pos - PW'(1);
                if (r_pos == PW'(1)) begin
                    out_load   = 1'b1;
                    out_status = STAT_ENQUEUED;
                end
            end
            default: begin
                sweep_go = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_pos    <= '0;
            r_thresh <= THRESH_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pos   <= n_pos;
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= out_status;
            if (out_head) begin
                r_out_tag  <= w_entry[0][EW-1:AGE_W+1];
                r_out_age  <= w_entry[0][AGE_W:1];
                r_out_flag <= w_entry[0][0];
            end else begin
                r_out_tag  <= '0;
                r_out_age  <= '0;
                r_out_flag <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_out_tag         = TAG_PORT_W'(r_out_tag);
    assign o_out_age         = r_out_age;
    assign o_out_health_flag = r_out_flag;

    // cell chain, head at index 0
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_cell_ctrl      ctrl;
        logic [EW-1:0]   left_entry, right_entry;
        logic [1:0]      left_class;
        logic            right_swap;

        assign ctrl.shift  = deq_go;
        assign ctrl.load   = enq_go && (r_count == CW'(k));
        assign ctrl.active = sweep_go && (r_pos == PW'(k));

        if (k == 0) begin : g_head
            assign left_entry = w_entry[k];
            assign left_class = w_class[k];
        end else begin : g_mid_l
            assign left_entry = w_entry[k-1];
            assign left_class = w_class[k-1];
        end

        if (k == CAPACITY - 1) begin : g_tail
            assign right_entry = '0;
            assign right_swap  = 1'b0;
        end else begin : g_mid_r
            assign right_entry = w_entry[k+1];
            assign right_swap  = w_swap[k+1];
        end

        fcspq_cell #(
            .ENTRY_W (EW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_thresh     (r_thresh),
            .i_new        (new_entry),
            .i_left       (left_entry),
            .i_left_class (left_class),
            .i_right      (right_entry),
            .i_right_swap (right_swap),
            .o_entry      (w_entry[k]),
            .o_class      (w_class[k]),
            .o_swap       (w_swap[k])
        );
    end

`ifndef SYNTHESIS
    // fill count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    // sweep token stays inside the filled part and never at the head
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> ((r_pos != '0) && (CW'(r_pos) < r_count)))
        else $error("sweep token out of range");

    // result register is free for the whole sweep
    a_sweep_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> !r_out_valid)
        else $error("result pending during sweep");

    // a served dequeue removes exactly one entry
    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !is_enq && (r_count != '0)) |=>
            (r_count == $past(r_count) - CW'(1)))
        else $error("dequeue count update wrong");
`endif

endmodule

// ----- rtl/fcspq_cell.sv -----
// ----------------------------------------------------------------------------
// fcspq_cell
// One slot of the queue chain: holds an entry, reports its class and trades
// entries with its neighbors on dequeue shifts and sweep swaps.
// ----------------------------------------------------------------------------
module fcspq_cell
    import fcspq_pkg::*;
#(
    parameter int ENTRY_W = 24
) (
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic [AGE_W-1:0]   i_thresh,
    input  logic [ENTRY_W-1:0] i_new,
    input  logic [ENTRY_W-1:0] i_left,
    input  logic [1:0]         i_left_class,
    input  logic [ENTRY_W-1:0] i_right,
    input  logic               i_right_swap,
    output logic [ENTRY_W-1:0] o_entry,
    output logic [1:0]         o_class,
    output logic               o_swap
);

    logic [ENTRY_W-1:0] r_entry;
    logic [ENTRY_W-1:0] n_entry;

    // class of the held entry, layout is {tag, age, flag}
    assign o_class = class_of(r_entry[AGE_W:1], r_entry[0], i_thresh);

    // token cell swaps with its left neighbor when that one ranks strictly lower
    assign o_swap = i_ctrl.active && (i_left_class < o_class);

    // next entry selection
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.shift) begin
            n_entry = i_right;
        end else if (i_ctrl.load) begin
            n_entry = i_new;
        end else if (o_swap) begin
            n_entry = i_left;
        end else if (i_right_swap) begin
            n_entry = i_right;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
